@@ rtl/wdcm_pkg.sv @@
// Shared types and constants for the wind direction circular mean block.
// Holds the controller/datapath command and status structs and the CORDIC table.
// No dependencies.
package wdcm_pkg;

	// CORDIC iterations for both sine/cosine and atan2.
	localparam int TRIG_BITS = 16;
	localparam int ITER_W    = $clog2(TRIG_BITS);

	// Starting x of the rotation CORDIC: round(0.60725293500888 * 2^(TRIG_BITS-2)).
	localparam logic signed [17:0] SC_X0 = 18'sd9949;

	// Angle units: 1/65536 of a tenth degree.
	localparam logic signed [31:0] HALF_TURN = 32'sd117964800;
	localparam logic signed [31:0] FULL_TURN = 32'sd235929600;
	localparam logic signed [31:0] ROUND_HALF = 32'sd32768;
	localparam logic [12:0] TENTHS_FULL = 13'd3600;

	// Register addresses (word index).
	localparam logic [1:0] REG_POLL_PERIOD = 2'd0;
	localparam logic [1:0] REG_STALE_LIMIT = 2'd1;
	localparam logic [1:0] REG_ERROR_LIMIT = 2'd2;

	// atan(2^-i) in degrees times 655360.
	localparam logic [25:0] ATAN_TAB [TRIG_BITS] = '{
		26'd29491200, 26'd17409672, 26'd9198793, 26'd4669451,
		26'd2343786,  26'd1173036,  26'd586661,  26'd293348,
		26'd146676,   26'd73339,    26'd36669,   26'd18335,
		26'd9167,     26'd4584,     26'd2292,    26'd1146
	};

	typedef struct packed {
		logic              load;     // capture input word
		logic              decide;   // poll period check, mirror direction
		logic              sc_init;  // start sine/cosine rotation
		logic              sc_step;  // one rotation iteration
		logic              ring_wr;  // write ring, clear sums
		logic              sum_step; // add one ring entry
		logic              at_init;  // start atan2 vectoring
		logic              at_step;  // one vectoring iteration
		logic              round;    // round angle to tenths, hold it
		logic              finish;   // update flags, load output register
		logic [ITER_W-1:0] iter;
	} wdcm_cmd_t;

	typedef struct packed {
		logic taken;    // poll period has elapsed
		logic ok;       // captured sample is good
		logic sum_done; // last ring entry being added
		logic out_free; // output register can take a result
	} wdcm_sts_t;

	function automatic logic signed [15:0] clamp_trig(input logic signed [17:0] v);
		logic signed [15:0] r;
		if (v > 18'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -18'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

@@ rtl/wdcm_ctrl.sv @@
// Sequencer for the wind direction circular mean block.
// Steps one poll attempt through the datapath. Depends on wdcm_pkg.
module wdcm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  wdcm_pkg::wdcm_sts_t sts,
	output wdcm_pkg::wdcm_cmd_t cmd
);
	import wdcm_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE    = 10'b0000000001,
		ST_DECIDE  = 10'b0000000010,
		ST_SC_INIT = 10'b0000000100,
		ST_SC_STEP = 10'b0000001000,
		ST_RING_WR = 10'b0000010000,
		ST_SUM     = 10'b0000100000,
		ST_AT_INIT = 10'b0001000000,
		ST_AT_STEP = 10'b0010000000,
		ST_ROUND   = 10'b0100000000,
		ST_FINISH  = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	logic [ITER_W-1:0] iter_q;
	logic last_iter;

	assign last_iter = (iter_q == ITER_W'(TRIG_BITS - 1));
	assign in_ready  = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.iter = iter_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d = (sts.taken && sts.ok) ? ST_SC_INIT : ST_FINISH;
			end
			ST_SC_INIT: begin
				cmd.sc_init = 1'b1;
				state_d = ST_SC_STEP;
			end
			ST_SC_STEP: begin
				cmd.sc_step = 1'b1;
				if (last_iter) state_d = ST_RING_WR;
			end
			ST_RING_WR: begin
				cmd.ring_wr = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum_step = 1'b1;
				if (sts.sum_done) state_d = ST_AT_INIT;
			end
			ST_AT_INIT: begin
				cmd.at_init = 1'b1;
				state_d = ST_AT_STEP;
			end
			ST_AT_STEP: begin
				cmd.at_step = 1'b1;
				if (last_iter) state_d = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				// hold until the output register is free
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iter_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.sc_step || cmd.at_step) begin
				iter_q <= last_iter ? '0 : iter_q + 1'b1;
			end
		end
	end

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state register not one-hot");
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> sts.out_free)
		else $error("result written while output register busy");
	a_sc_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SC_STEP && last_iter) |=> (state_q == ST_RING_WR && iter_q == '0))
		else $error("rotation did not end after the last iteration");
	a_iter_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (iter_q == '0))
		else $error("iteration count left nonzero");

endmodule

@@ rtl/wdcm_dp.sv @@
// Datapath for the wind direction circular mean block: poll timing, CORDIC
// sine/cosine and atan2, sample ring, flags and output register. Depends on wdcm_pkg.
module wdcm_dp #(
	parameter int WINDOW_TAPS = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  wdcm_pkg::wdcm_cmd_t cmd,
	output wdcm_pkg::wdcm_sts_t sts,
	input  logic [31:0]        now_ms,
	input  logic               sample_ok,
	input  logic [15:0]        wind_speed,
	input  logic [11:0]        raw_direction,
	input  logic [15:0]        poll_period_ms,
	input  logic [15:0]        stale_limit_ms,
	input  logic [7:0]         error_limit,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        speed_out,
	output logic [11:0]        direction_out,
	output logic               data_valid,
	output logic               poll_taken,
	output logic               sensor_error
);
	import wdcm_pkg::*;

	localparam int TAPW = (WINDOW_TAPS > 1) ? $clog2(WINDOW_TAPS) : 1;
	localparam int SW   = 16 + $clog2(WINDOW_TAPS);
	localparam int AW   = SW + 3;

	// captured word
	logic [31:0] now_q;
	logic        ok_q;
	logic [15:0] spd_q;
	logic [11:0] dir_q;

	// state
	logic [31:0] last_poll_q, last_good_q;
	logic [7:0]  fail_q;
	logic        valid_q, taken_q;
	logic [15:0] held_speed_q;
	logic [11:0] held_dir_q;
	logic [11:0] cw_q;

	logic signed [15:0] sin_ring_q [WINDOW_TAPS];
	logic signed [15:0] cos_ring_q [WINDOW_TAPS];
	logic [TAPW-1:0]    idx_q, tap_q;

	// rotation CORDIC
	logic signed [17:0] xs_q, ys_q;
	logic signed [27:0] zs_q;
	logic [1:0]         quad_q;

	// sums and vectoring CORDIC
	logic signed [SW-1:0] ssum_q, csum_q;
	logic signed [AW-1:0] xa_q, ya_q;
	logic signed [31:0]   za_q;
	logic                 zero_q;

	// output register
	logic        ovalid_q;
	logic [15:0] ospd_q;
	logic [11:0] odir_q;
	logic        ovld_q, otaken_q, oerr_q;

	logic [31:0] elapsed;
	logic [11:0] dir_red, cw;
	logic [1:0]  quad;
	logic [9:0]  rem;
	logic signed [17:0] sn, cs;
	logic signed [31:0] tot, rnd;
	logic [12:0] tenths, tenths_w;
	logic [7:0]  fail_inc;
	logic        fail_hit, stale_hit, valid_d;

	assign elapsed = now_q - last_poll_q;
	assign sts.taken = (elapsed >= {16'd0, poll_period_ms});
	assign sts.ok = ok_q;
	assign sts.sum_done = (tap_q == TAPW'(WINDOW_TAPS - 1));
	assign sts.out_free = !ovalid_q || out_ready;

	// mirror counter-clockwise to clockwise
	assign dir_red = (dir_q >= 12'd3600) ? dir_q - 12'd3600 : dir_q;
	assign cw = (dir_red == 12'd0) ? 12'd0 : 12'd3600 - dir_red;

	always_comb begin
		if (cw_q >= 12'd2700) begin
			quad = 2'd3; rem = 10'(cw_q - 12'd2700);
		end else if (cw_q >= 12'd1800) begin
			quad = 2'd2; rem = 10'(cw_q - 12'd1800);
		end else if (cw_q >= 12'd900) begin
			quad = 2'd1; rem = 10'(cw_q - 12'd900);
		end else begin
			quad = 2'd0; rem = 10'(cw_q);
		end
	end

	always_comb begin
		case (quad_q)
			2'd0: begin sn = ys_q;  cs = xs_q;  end
			2'd1: begin sn = xs_q;  cs = -ys_q; end
			2'd2: begin sn = -ys_q; cs = -xs_q; end
			default: begin sn = -xs_q; cs = ys_q; end
		endcase
	end

	assign tot = (za_q < 0) ? za_q + FULL_TURN : za_q;
	assign rnd = tot + ROUND_HALF;
	assign tenths = rnd[28:16];
	assign tenths_w = (tenths >= TENTHS_FULL) ? tenths - TENTHS_FULL : tenths;
	assign fail_inc = (fail_q == 8'hFF) ? fail_q : fail_q + 8'd1;
	assign fail_hit = (fail_inc >= error_limit);
	// stale guard on the last good sample
	assign stale_hit = valid_q && ((now_q - last_good_q) > {16'd0, stale_limit_ms});

	// valid flag after this attempt
	always_comb begin
		valid_d = valid_q;
		if (taken_q) begin
			if (ok_q) begin
				valid_d = 1'b1;
			end else if (fail_hit || stale_hit) begin
				valid_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			now_q <= now_ms;
			spd_q <= wind_speed;
			dir_q <= raw_direction;
		end
		if (cmd.decide) cw_q <= cw;
		if (cmd.sc_init) begin
			xs_q <= SC_X0;
			ys_q <= '0;
			zs_q <= $signed({2'b00, rem, 16'd0});
			quad_q <= quad;
		end else if (cmd.sc_step) begin
			if (zs_q >= 0) begin
				xs_q <= xs_q - (ys_q >>> cmd.iter);
				ys_q <= ys_q + (xs_q >>> cmd.iter);
				zs_q <= zs_q - $signed({2'b00, ATAN_TAB[cmd.iter]});
			end else begin
				xs_q <= xs_q + (ys_q >>> cmd.iter);
				ys_q <= ys_q - (xs_q >>> cmd.iter);
				zs_q <= zs_q + $signed({2'b00, ATAN_TAB[cmd.iter]});
			end
		end
		if (cmd.ring_wr) begin
			ssum_q <= '0;
			csum_q <= '0;
		end else if (cmd.sum_step) begin
			ssum_q <= ssum_q + SW'(sin_ring_q[tap_q]);
			csum_q <= csum_q + SW'(cos_ring_q[tap_q]);
		end
		if (cmd.at_init) begin
			zero_q <= (ssum_q == '0) && (csum_q == '0);
			if (csum_q < 0) begin
				xa_q <= -AW'(csum_q);
				ya_q <= -AW'(ssum_q);
				za_q <= HALF_TURN;
			end else begin
				xa_q <= AW'(csum_q);
				ya_q <= AW'(ssum_q);
				za_q <= '0;
			end
		end else if (cmd.at_step) begin
			if (ya_q >= 0) begin
				xa_q <= xa_q + (ya_q >>> cmd.iter);
				ya_q <= ya_q - (xa_q >>> cmd.iter);
				za_q <= za_q + $signed({6'd0, ATAN_TAB[cmd.iter]});
			end else begin
				xa_q <= xa_q - (ya_q >>> cmd.iter);
				ya_q <= ya_q + (xa_q >>> cmd.iter);
				za_q <= za_q - $signed({6'd0, ATAN_TAB[cmd.iter]});
			end
		end
		if (cmd.finish) begin
			ospd_q <= (taken_q && ok_q) ? spd_q : held_speed_q;
			odir_q <= held_dir_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q         <= 1'b0;
			taken_q      <= 1'b0;
			last_poll_q  <= '0;
			last_good_q  <= '0;
			fail_q       <= '0;
			valid_q      <= 1'b0;
			held_speed_q <= '0;
			held_dir_q   <= '0;
			idx_q        <= '0;
			tap_q        <= '0;
			ovalid_q     <= 1'b0;
			ovld_q       <= 1'b0;
			otaken_q     <= 1'b0;
			oerr_q       <= 1'b0;
			for (int i = 0; i < WINDOW_TAPS; i++) begin
				sin_ring_q[i] <= '0;
				cos_ring_q[i] <= '0;
			end
		end else begin
			if (cmd.load) ok_q <= sample_ok;
			if (cmd.decide) begin
				taken_q <= sts.taken;
				if (sts.taken) last_poll_q <= now_q;
			end
			if (cmd.ring_wr) begin
				sin_ring_q[idx_q] <= clamp_trig(sn);
				cos_ring_q[idx_q] <= clamp_trig(cs);
				idx_q <= (idx_q == TAPW'(WINDOW_TAPS - 1)) ? '0 : idx_q + 1'b1;
				tap_q <= '0;
			end else if (cmd.sum_step && !sts.sum_done) begin
				tap_q <= tap_q + 1'b1;
			end
			if (cmd.round) held_dir_q <= zero_q ? 12'd0 : tenths_w[11:0];
			if (cmd.finish) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
			if (cmd.finish) begin
				otaken_q <= taken_q;
				oerr_q   <= taken_q && !ok_q && fail_hit;
				ovld_q   <= valid_d;
				valid_q  <= valid_d;
				if (taken_q) begin
					if (ok_q) begin
						fail_q       <= '0;
						held_speed_q <= spd_q;
						last_good_q  <= now_q;
					end else if (fail_hit) begin
						fail_q <= '0;
					end else begin
						fail_q <= fail_inc;
					end
				end
			end
		end
	end

	assign out_valid     = ovalid_q;
	assign speed_out     = ospd_q;
	assign direction_out = odir_q;
	assign data_valid    = ovld_q;
	assign poll_taken    = otaken_q;
	assign sensor_error  = oerr_q;

endmodule

@@ rtl/wind_direction_circular_mean.sv @@
// Top level of the wind direction circular mean block: stream ports, APB
// registers and the controller/datapath pair. Depends on wdcm_pkg, wdcm_ctrl, wdcm_dp.
//
// Each input word is one poll attempt. An attempt counts only once poll_period_ms
// have passed since the last counted one (time differences wrap modulo 2^32).
// A good sample latches the speed, mirrors the counter-clockwise direction to
// clockwise, and pushes its sine and cosine into a WINDOW_TAPS deep ring; the
// output direction is atan2 of the ring sums in tenths of a degree (0..3599, a
// zero vector gives 0). Failed attempts count up; reaching error_limit raises
// sensor_error, drops data_valid and clears the count. A sample older than
// stale_limit_ms also drops data_valid. Every input word yields exactly one
// result word. A good, counted attempt runs from one accepted word to the next
// through two 16 step CORDIC passes on one shared iteration counter, a sum over
// the WINDOW_TAPS ring entries, and seven further steps (accept, decide, two
// CORDIC starts, ring write, rounding, result); any other attempt goes from
// accept through decide to the result step. The result step holds while the
// previous result still waits in the output register and is not taken that
// cycle. One attempt is worked on at a time, and a new word is taken while the
// previous result still waits in the output register.
module wind_direction_circular_mean #(
	parameter int WINDOW_TAPS = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // now_ms[31:0], wind_speed[47:32], raw_direction[59:48]
	input  logic        s_axis_tuser,  // sample_ok
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // speed_out[15:0], direction_out[27:16]
	output logic [2:0]  m_axis_tuser,  // data_valid, poll_taken, sensor_error
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import wdcm_pkg::*;

	wdcm_cmd_t cmd;
	wdcm_sts_t sts;

	logic [15:0] poll_period_q, stale_limit_q;
	logic [7:0]  error_limit_q;
	logic        wr_en;

	logic [15:0] speed_out;
	logic [11:0] direction_out;
	logic        data_valid, poll_taken, sensor_error;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// register writes; an unknown address is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_period_q <= 16'd200;
			stale_limit_q <= 16'd1500;
			error_limit_q <= 8'd5;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_POLL_PERIOD: poll_period_q <= pwdata[15:0];
				REG_STALE_LIMIT: stale_limit_q <= pwdata[15:0];
				REG_ERROR_LIMIT: error_limit_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_POLL_PERIOD: prdata = {16'd0, poll_period_q};
			REG_STALE_LIMIT: prdata = {16'd0, stale_limit_q};
			REG_ERROR_LIMIT: prdata = {24'd0, error_limit_q};
			default:         prdata = '0;
		endcase
	end

	wdcm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wdcm_dp #(
		.WINDOW_TAPS (WINDOW_TAPS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.now_ms         (s_axis_tdata[31:0]),
		.sample_ok      (s_axis_tuser),
		.wind_speed     (s_axis_tdata[47:32]),
		.raw_direction  (s_axis_tdata[59:48]),
		.poll_period_ms (poll_period_q),
		.stale_limit_ms (stale_limit_q),
		.error_limit    (error_limit_q),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.speed_out      (speed_out),
		.direction_out  (direction_out),
		.data_valid     (data_valid),
		.poll_taken     (poll_taken),
		.sensor_error   (sensor_error)
	);

	assign m_axis_tdata = {4'd0, direction_out, speed_out};
	assign m_axis_tuser = {sensor_error, poll_taken, data_valid};

endmodule
